@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers used by the span filler top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Consequent holds in the same cycle as the antecedent.
`define ATSF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Consequent holds in the cycle after the antecedent.
`define ATSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ATSF_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define ATSF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/atsf_pkg.sv @@
// ----------------------------------------------------------------------------
// Span filler package
// Shared constants, operation codes and the pixel tag type.
// ----------------------------------------------------------------------------
package atsf_pkg;

  localparam int TEX_SIZE_LOG2_DEF   = 8;
  localparam int MAX_SPAN_PIXELS_DEF = 64;

  localparam logic [7:0] COORD_MASK_RESET = 8'hFF;

  // Operation codes of an input transfer.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_DRAW = 1'b1;

  // Side information that travels with each pixel down the pipeline.
  typedef struct packed {
    logic [11:0] x;
    logic [9:0]  y;
    logic        last;
    logic        truncated;
  } pix_tag_t;

endpackage

@@ rtl/atsf_span_if.sv @@
// ----------------------------------------------------------------------------
// Span input channel
// Valid/ready channel carrying texel loads and span draw commands.
// ----------------------------------------------------------------------------
interface atsf_span_if;
  logic               valid;
  logic               ready;
  logic               operation;
  logic [15:0]        texel_address;
  logic [31:0]        texel_value;
  logic [9:0]         row_y;
  logic signed [19:0] left_x;
  logic signed [19:0] right_x;
  logic signed [23:0] u_start;
  logic signed [23:0] v_start;
  logic signed [23:0] u_step;
  logic signed [23:0] v_step;

  modport source (
    output valid, operation, texel_address, texel_value, row_y,
           left_x, right_x, u_start, v_start, u_step, v_step,
    input  ready
  );
  modport sink (
    input  valid, operation, texel_address, texel_value, row_y,
           left_x, right_x, u_start, v_start, u_step, v_step,
    output ready
  );
endinterface

@@ rtl/atsf_pixel_if.sv @@
// ----------------------------------------------------------------------------
// Pixel output channel
// Valid/ready channel carrying one textured pixel per transfer.
// ----------------------------------------------------------------------------
interface atsf_pixel_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] pixel_x;
  logic [9:0]         pixel_y;
  logic [31:0]        pixel_color;
  logic               last;
  logic               truncated;

  modport source (
    output valid, pixel_x, pixel_y, pixel_color, last, truncated,
    input  ready
  );
  modport sink (
    input  valid, pixel_x, pixel_y, pixel_color, last, truncated,
    output ready
  );
endinterface

@@ rtl/atsf_tex_mem.sv @@
// ----------------------------------------------------------------------------
// Texel store
// Single-port-write, single-port-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module atsf_tex_mem #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read register holds while re is low, which lets the pipeline stall.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/atsf_span_gen.sv @@
// ----------------------------------------------------------------------------
// Span walker
// Sets up one span, steps the u/v accumulators per pixel and registers the
// scaled coordinates for the texel fetch.
// ----------------------------------------------------------------------------
module atsf_span_gen #(
  parameter int TEX_SIZE_LOG2   = atsf_pkg::TEX_SIZE_LOG2_DEF,
  parameter int MAX_SPAN_PIXELS = atsf_pkg::MAX_SPAN_PIXELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [9:0]                   row_y,
  input  logic signed [19:0]           left_x,
  input  logic signed [19:0]           right_x,
  input  logic signed [23:0]           u_start,
  input  logic signed [23:0]           v_start,
  input  logic signed [23:0]           u_step,
  input  logic signed [23:0]           v_step,
  input  logic [TEX_SIZE_LOG2-1:0]     mask,
  input  logic                         adv,
  output logic                         ready,
  output logic                         s1_valid,
  output logic [24+TEX_SIZE_LOG2-1:0]  prod_u,
  output logic [24+TEX_SIZE_LOG2-1:0]  prod_v,
  output atsf_pkg::pix_tag_t           s1_tag
);

  localparam int AccW = 24 + TEX_SIZE_LOG2;
  localparam int CntW = $clog2(MAX_SPAN_PIXELS + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_PRE, ST_WALK} state_t;

  state_t             state;
  logic [9:0]         row;
  logic signed [19:0] left;
  logic signed [19:0] right;
  logic signed [23:0] u0;
  logic signed [23:0] v0;
  logic signed [23:0] du;
  logic signed [23:0] dv;
  logic [7:0]         frac;
  logic [11:0]        x;
  logic [CntW-1:0]    remaining;
  logic               cut;
  logic [AccW-1:0]    acc_u;
  logic [AccW-1:0]    acc_v;

  logic signed [20:0] lsum;
  logic signed [20:0] rsum;
  logic signed [12:0] minx;
  logic signed [12:0] ceil_r;
  logic signed [13:0] cnt;
  logic [20:0]        frac_full;
  logic signed [32:0] pre_u;
  logic signed [32:0] pre_v;
  logic [AccW-1:0]    acc_u_init;
  logic [AccW-1:0]    acc_v_init;
  logic [AccW-1:0]    inc_u;
  logic [AccW-1:0]    inc_v;
  logic               at_last;

  // Ceiling of a Q12.8 value is the floor of the value plus 255/256.
  assign lsum      = 21'(left) + 21'sd255;
  assign rsum      = 21'(right) + 21'sd255;
  assign minx      = lsum[20:8];
  assign ceil_r    = rsum[20:8];
  assign cnt       = 14'(ceil_r) - 14'(minx);
  assign frac_full = {minx, 8'h00} - 21'(left);

  // Pre-step from the left edge to the first pixel center, kept exact in Q.24.
  assign pre_u      = $signed({1'b0, frac}) * du;
  assign pre_v      = $signed({1'b0, frac}) * dv;
  assign acc_u_init = (AccW'(u0) << 8) + AccW'(pre_u);
  assign acc_v_init = (AccW'(v0) << 8) + AccW'(pre_v);
  assign inc_u      = AccW'(du) << 8;
  assign inc_v      = AccW'(dv) << 8;

  assign at_last = (remaining == CntW'(1));
  assign ready   = (state == ST_IDLE) && !s1_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      s1_valid <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid <= (state == ST_WALK);
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            row   <= row_y;
            left  <= left_x;
            right <= right_x;
            u0    <= u_start;
            v0    <= v_start;
            du    <= u_step;
            dv    <= v_step;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (cnt <= 14'sd0) begin
            state <= ST_IDLE;
          end else begin
            x    <= minx[11:0];
            frac <= frac_full[7:0];
            if (cnt > 14'(MAX_SPAN_PIXELS)) begin
              remaining <= CntW'(MAX_SPAN_PIXELS);
              cut       <= 1'b1;
            end else begin
              remaining <= CntW'(cnt);
              cut       <= 1'b0;
            end
            state <= ST_PRE;
          end
        end
        ST_PRE: begin
          acc_u <= acc_u_init;
          acc_v <= acc_v_init;
          state <= ST_WALK;
        end
        ST_WALK: begin
          if (adv) begin
            prod_u           <= acc_u * AccW'(mask);
            prod_v           <= acc_v * AccW'(mask);
            s1_tag.x         <= x;
            s1_tag.y         <= row;
            s1_tag.last      <= at_last;
            s1_tag.truncated <= at_last && cut;
            acc_u            <= acc_u + inc_u;
            acc_v            <= acc_v + inc_v;
            x                <= x + 12'd1;
            remaining        <= remaining - CntW'(1);
            if (at_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/affine_texture_span_filler_top.sv @@
// ----------------------------------------------------------------------------
// Affine texture span filler
// Loads texels into a square texture store and fills horizontal spans with
// affine-mapped texels, one pixel per cycle while pixel_out does not stall.
// ----------------------------------------------------------------------------
//   Channel    Dir  Carries
//   span_in    in   texel load or span draw command
//   pixel_out  out  one textured pixel per transfer
//   cfg_*      in   texture coordinate mask register
//
// A load is written straight into the texel store. A draw first sets up (latch,
// span bounds, pre-step), then issues one pixel per cycle, unless pixel_out
// stalls, through the multiply stage and the texel store read port.
// The next command is taken once the multiply stage has drained. A stall on
// pixel_out freezes the whole pixel pipeline. Reset is synchronous, active
// high, and restores the mask to all ones; the texel store is not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module affine_texture_span_filler_top #(
  parameter int TEX_SIZE_LOG2   = atsf_pkg::TEX_SIZE_LOG2_DEF,
  parameter int MAX_SPAN_PIXELS = atsf_pkg::MAX_SPAN_PIXELS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  atsf_span_if.sink   span_in,
  atsf_pixel_if.source pixel_out,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data
);

  localparam int AccW  = 24 + TEX_SIZE_LOG2;
  localparam int AddrW = 2 * TEX_SIZE_LOG2;

  logic [7:0]                 coord_mask;
  logic [TEX_SIZE_LOG2+7:0]   mask_ext;
  logic [TEX_SIZE_LOG2-1:0]   mask;
  logic                       in_xfer;
  logic                       draw_start;
  logic                       mem_we;
  logic [AddrW+15:0]          waddr_ext;
  logic                       gen_ready;
  logic                       s1_valid;
  logic [AccW-1:0]            prod_u;
  logic [AccW-1:0]            prod_v;
  atsf_pkg::pix_tag_t         s1_tag;
  logic [AccW-1:0]            rnd_u;
  logic [AccW-1:0]            rnd_v;
  logic [TEX_SIZE_LOG2-1:0]   iu;
  logic [TEX_SIZE_LOG2-1:0]   iv;
  logic                       adv;
  logic                       s2_valid;
  atsf_pkg::pix_tag_t         s2_tag;
  logic [31:0]                rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      coord_mask <= atsf_pkg::COORD_MASK_RESET;
    end else if (cfg_we) begin
      coord_mask <= cfg_data;
    end
  end

  assign mask_ext = {{TEX_SIZE_LOG2{1'b0}}, coord_mask};
  assign mask     = mask_ext[TEX_SIZE_LOG2-1:0];

  assign span_in.ready = gen_ready;
  assign in_xfer       = span_in.valid && gen_ready;
  assign draw_start    = in_xfer && (span_in.operation == atsf_pkg::OP_DRAW);
  assign mem_we        = in_xfer && (span_in.operation == atsf_pkg::OP_LOAD);
  assign waddr_ext     = {{AddrW{1'b0}}, span_in.texel_address};

  atsf_span_gen #(
    .TEX_SIZE_LOG2   (TEX_SIZE_LOG2),
    .MAX_SPAN_PIXELS (MAX_SPAN_PIXELS)
  ) u_gen (
    .clk      (clk),
    .rst      (rst),
    .start    (draw_start),
    .row_y    (span_in.row_y),
    .left_x   (span_in.left_x),
    .right_x  (span_in.right_x),
    .u_start  (span_in.u_start),
    .v_start  (span_in.v_start),
    .u_step   (span_in.u_step),
    .v_step   (span_in.v_step),
    .mask     (mask),
    .adv      (adv),
    .ready    (gen_ready),
    .s1_valid (s1_valid),
    .prod_u   (prod_u),
    .prod_v   (prod_v),
    .s1_tag   (s1_tag)
  );

  // Round to nearest with ties up, then wrap with the mask.
  assign rnd_u = prod_u + (AccW'(1) << 23);
  assign rnd_v = prod_v + (AccW'(1) << 23);
  assign iu    = rnd_u[AccW-1:24] & mask;
  assign iv    = rnd_v[AccW-1:24] & mask;

  assign adv = !s2_valid || pixel_out.ready;

  atsf_tex_mem #(
    .ADDR_W (AddrW),
    .DATA_W (32)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (waddr_ext[AddrW-1:0]),
    .wdata (span_in.texel_value),
    .re    (adv),
    .raddr ({iu, iv}),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
      s2_tag   <= s1_tag;
    end
  end

  assign pixel_out.valid       = s2_valid;
  assign pixel_out.pixel_x     = $signed(s2_tag.x);
  assign pixel_out.pixel_y     = s2_tag.y;
  assign pixel_out.pixel_color = rdata;
  assign pixel_out.last        = s2_tag.last;
  assign pixel_out.truncated   = s2_tag.truncated;

  // A texel load must never overtake a fetch that is still in flight.
  `ATSF_ASSERT_SAME(a_no_write_during_fetch, clk, rst, mem_we, !s1_valid, "texel write while fetch pending")
  // A pixel leaving the multiply stage must show up in the output register.
  `ATSF_ASSERT_NEXT(a_fetch_lands, clk, rst, adv && s1_valid, s2_valid, "fetched pixel lost")
  // The cut flag only ever marks the final pixel of a span.
  `ATSF_ASSERT_SAME(a_trunc_on_last, clk, rst, s2_valid && s2_tag.truncated, s2_tag.last, "truncated without last")

endmodule

@@ bench/atsf_span_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span filler checker
// Watches the command, pixel and mask ports of the span filler. It keeps its
// own texture store and mask, works out the pixels of every accepted span
// and compares each pixel transfer, in order, with the oldest one expected.
// ----------------------------------------------------------------------------
module atsf_span_checker (
  input  logic       clk,
  input  logic       rst,
  atsf_span_if       span_mon,
  atsf_pixel_if      pixel_mon,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  output int         mismatches,
  output int         pixels_outstanding,
  output int         pixels_checked
);

  localparam int SPAN_LIMIT = atsf_pkg::MAX_SPAN_PIXELS_DEF;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [11:0] x;
    logic [9:0]  y;
    logic [31:0] color;
    logic        last;
    logic        truncated;
  } pixel_t;

  logic [31:0] texels [0:65535];
  logic [7:0]  coord_mask;
  pixel_t      pixels_due [$];
  int          fail_cnt = 0;
  int          checked_cnt = 0;

  // Scale a Q.24 coordinate by the mask, round half up and wrap it.
  function automatic logic [7:0] texel_coord(logic [63:0] acc, logic [7:0] mask);
    logic [63:0] scaled;
    scaled = acc * {56'd0, mask} + 64'h0080_0000;
    return scaled[31:24] & mask;
  endfunction

  task automatic queue_span_pixels();
    longint      lx, rx, su, sv, du, dv, first_col, last_col, frac;
    int          n;
    logic        cut;
    logic [63:0] acc_u, acc_v, inc_u, inc_v;
    logic [7:0]  tu, tv;
    pixel_t      px;
    lx = span_mon.left_x;
    rx = span_mon.right_x;
    su = span_mon.u_start;
    sv = span_mon.v_start;
    du = span_mon.u_step;
    dv = span_mon.v_step;
    // An arithmetic shift of (q + 255) gives the ceiling of a Q12.8 value.
    first_col = (lx + 255) >>> 8;
    last_col  = ((rx + 255) >>> 8) - 1;
    if (first_col > last_col) return;
    n   = int'(last_col - first_col + 1);
    cut = (n > SPAN_LIMIT);
    if (cut) n = SPAN_LIMIT;
    // Move u and v from the left edge to the center of the first column.
    frac  = first_col * 256 - lx;
    acc_u = su * 256 + frac * du;
    acc_v = sv * 256 + frac * dv;
    inc_u = du * 256;
    inc_v = dv * 256;
    for (int k = 0; k < n; k++) begin
      tu = texel_coord(acc_u, coord_mask);
      tv = texel_coord(acc_v, coord_mask);
      px.x         = 12'(first_col + k);
      px.y         = span_mon.row_y;
      px.color     = texels[{tu, tv}];
      px.last      = (k == n - 1);
      px.truncated = (k == n - 1) && cut;
      pixels_due.push_back(px);
      acc_u += inc_u;
      acc_v += inc_v;
    end
  endtask

  task automatic compare_pixel();
    pixel_t got, want;
    got = {pixel_mon.pixel_x, pixel_mon.pixel_y, pixel_mon.pixel_color,
           pixel_mon.last, pixel_mon.truncated};
    if (pixels_due.size() == 0) begin
      fail_cnt++;
      if (fail_cnt <= REPORT_MAX)
        $display("%t: pixel transfer with none expected: x=%0d y=%0d color=%h",
                 $realtime, $signed(got.x), got.y, got.color);
      return;
    end
    want = pixels_due.pop_front();
    checked_cnt++;
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= REPORT_MAX) begin
        $display("%t: pixel mismatch", $realtime);
        $display("  expected x=%0d y=%0d color=%h last=%b truncated=%b",
                 $signed(want.x), want.y, want.color, want.last, want.truncated);
        $display("  actual   x=%0d y=%0d color=%h last=%b truncated=%b",
                 $signed(got.x), got.y, got.color, got.last, got.truncated);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      coord_mask = atsf_pkg::COORD_MASK_RESET;
    end else begin
      if (cfg_we) coord_mask = cfg_data;
      if (span_mon.valid && span_mon.ready) begin
        if (span_mon.operation == atsf_pkg::OP_LOAD)
          texels[span_mon.texel_address] = span_mon.texel_value;
        else
          queue_span_pixels();
      end
      if (pixel_mon.valid && pixel_mon.ready) compare_pixel();
    end
    mismatches         <= fail_cnt;
    pixels_outstanding <= pixels_due.size();
    pixels_checked     <= checked_cnt;
  end

endmodule

@@ bench/tb_affine_texture_span_filler_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Span filler testbench
// Fills every texel that the chosen masks can reach, then sends directed and
// random texel loads and span draws under several coordinate masks and
// handshake pressure phases. A checker beside the block predicts and
// compares every pixel.
// ----------------------------------------------------------------------------
module tb_affine_texture_span_filler_top;

  // All masks used below are subsets of this one, so the preload covers
  // every texel a span can fetch.
  localparam logic [7:0] PRELOAD_MASK = 8'h83;
  localparam int SEGMENTS     = 8;
  localparam int SEG_ITEMS    = 18;
  localparam int DRAIN_LIMIT  = 200000;
  localparam int SETTLE_TICKS = 12;

  typedef struct {
    logic               op;
    logic [15:0]        addr;
    logic [31:0]        value;
    logic [9:0]         row;
    logic signed [19:0] lx;
    logic signed [19:0] rx;
    logic signed [23:0] u0;
    logic signed [23:0] v0;
    logic signed [23:0] du;
    logic signed [23:0] dv;
  } span_cmd_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_data;
  int         mismatches;
  int         pixels_outstanding;
  int         pixels_checked;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  int         n_loads = 0;
  int         n_draws = 0;
  int         n_masks = 0;

  atsf_span_if  span_in ();
  atsf_pixel_if pixel_out ();

  affine_texture_span_filler_top u_top (
    .clk       (clk),
    .rst       (rst),
    .span_in   (span_in),
    .pixel_out (pixel_out),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  atsf_span_checker u_checker (
    .clk                (clk),
    .rst                (rst),
    .span_mon           (span_in),
    .pixel_mon          (pixel_out),
    .cfg_we             (cfg_we),
    .cfg_data           (cfg_data),
    .mismatches         (mismatches),
    .pixels_outstanding (pixels_outstanding),
    .pixels_checked     (pixels_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Timed out with %0d pixels still expected.", pixels_outstanding);
    $display("** affine_texture_span_filler_top: FAILED **");
    $finish;
  end

  initial begin
    pixel_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      pixel_out.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  function automatic span_cmd_t make_load(logic [15:0] addr, logic [31:0] value);
    span_cmd_t c;
    c = '{op: atsf_pkg::OP_LOAD, addr: addr, value: value, row: 10'($urandom),
          lx: 20'($urandom), rx: 20'($urandom), u0: 24'($urandom), v0: 24'($urandom),
          du: 24'($urandom), dv: 24'($urandom)};
    return c;
  endfunction

  function automatic span_cmd_t make_draw(logic [9:0] row, int lx, int rx,
                                          int u0, int v0, int du, int dv);
    span_cmd_t c;
    c = '{op: atsf_pkg::OP_DRAW, addr: 16'($urandom), value: $urandom, row: row,
          lx: 20'(lx), rx: 20'(rx), u0: 24'(u0), v0: 24'(v0), du: 24'(du),
          dv: 24'(dv)};
    return c;
  endfunction

  function automatic int coord_step();
    if ($urandom_range(0, 1) == 0) return int'($urandom_range(0, 65536)) - 32768;
    return $urandom;
  endfunction

  // Texel loads and mostly well-formed spans of modest width; now and then a
  // long or fully random span.
  function automatic span_cmd_t random_cmd();
    int kind, lx, w;
    kind = $urandom_range(0, 9);
    if (kind < 4) return make_load(16'($urandom), $urandom);
    if (kind == 9)
      return make_draw(10'($urandom), $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
    lx = int'($urandom_range(256, 1048575 - 90 * 256)) - 524288;
    w  = ($urandom_range(0, 7) == 0) ? $urandom_range(56, 80) : $urandom_range(0, 20);
    return make_draw(10'($urandom), lx, lx + w * 256 + int'($urandom_range(0, 255)) - 128,
                     $urandom, $urandom, coord_step(), coord_step());
  endfunction

  task automatic send_cmd(input span_cmd_t c);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      span_in.valid <= 1'b0;
      @(posedge clk);
    end
    span_in.valid         <= 1'b1;
    span_in.operation     <= c.op;
    span_in.texel_address <= c.addr;
    span_in.texel_value   <= c.value;
    span_in.row_y         <= c.row;
    span_in.left_x        <= c.lx;
    span_in.right_x       <= c.rx;
    span_in.u_start       <= c.u0;
    span_in.v_start       <= c.v0;
    span_in.u_step        <= c.du;
    span_in.v_step        <= c.dv;
    do @(posedge clk); while (!span_in.ready);
    if (c.op == atsf_pkg::OP_LOAD) n_loads++;
    else n_draws++;
  endtask

  // Waits for every expected pixel, then lets a trailing load finish.
  task automatic wait_drained();
    int guard;
    guard = 0;
    span_in.valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (pixels_outstanding != 0 && guard < DRAIN_LIMIT);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_mask(input logic [7:0] m);
    wait_drained();
    cfg_we   <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_masks++;
  endtask

  initial begin
    logic [7:0] mask_plan [SEGMENTS];
    mask_plan = '{8'd0, PRELOAD_MASK, 8'd1, 8'd3, 8'($urandom) & PRELOAD_MASK,
                  8'd128, 8'd130, 8'($urandom) & PRELOAD_MASK};
    rst                   <= 1'b1;
    cfg_we                <= 1'b0;
    cfg_data              <= 8'd0;
    span_in.valid         <= 1'b0;
    span_in.operation     <= atsf_pkg::OP_LOAD;
    span_in.texel_address <= '0;
    span_in.texel_value   <= '0;
    span_in.row_y         <= '0;
    span_in.left_x        <= '0;
    span_in.right_x       <= '0;
    span_in.u_start       <= '0;
    span_in.v_start       <= '0;
    span_in.u_step        <= '0;
    span_in.v_step        <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every texel that the masks below can reach gets a value first, so no
    // span ever reads an empty entry.
    for (int a = 0; a < 256; a++) begin
      if ((8'(a) & ~PRELOAD_MASK) == 8'd0) begin
        for (int b = 0; b < 256; b++) begin
          if ((8'(b) & ~PRELOAD_MASK) == 8'd0)
            send_cmd(make_load({a[7:0], b[7:0]}, $urandom));
        end
      end
    end
    write_mask(PRELOAD_MASK);

    // Directed: extreme words, a rounding tie on both sides of zero, full-range
    // and cut spans, empty and reversed spans, fractional and negative edges.
    send_cmd(make_load(16'h0000, 32'hFFFF_FFFF));
    send_cmd(make_load(16'hFFFF, 32'h0000_0000));
    send_cmd(make_load(16'h8080, 32'hA5A5_A5A5));
    send_cmd(make_draw(10'd0, 0, 256, 'h008000, 'h008000, 0, 0));
    send_cmd(make_draw(10'd1023, -524288, 524287, 'h7FFFFF, 'h800000,
                       'h7FFFFF, 'h800000));
    send_cmd(make_draw(10'd5, 1000, 1000, $urandom, $urandom, $urandom, $urandom));
    send_cmd(make_draw(10'd6, 5000, 100, $urandom, $urandom, $urandom, $urandom));
    send_cmd(make_draw(10'd7, 0, 64 * 256, 'h000000, 'h000000,
                       'h000400, 'h000400));
    send_cmd(make_draw(10'd8, -2560, 55 * 256, 'h123456, 'hFEDCBA,
                       'hFFF000, 'h001000));
    send_cmd(make_draw(10'd9, -129, 5 * 256 + 1, 'h000000, 'h000000,
                       'h001000, 'h002000));
    send_cmd(make_draw(10'd10, 300 * 256 + 17, 310 * 256, 'h000000, 'h000000,
                       'h800000, 'h7FFFFF));
    send_cmd(make_load(16'h1234, $urandom));
    send_cmd(make_draw(10'd11, -2000 * 256 + 77, -1990 * 256, 'hFF8000,
                       'hFF8000, 'h000000, 'h000000));
    send_cmd(make_draw(10'd12, -524288, -524288 + 3 * 256, 'h7FFFFF, 'h7FFFFF,
                       'h000100, 'hFFFF00));

    for (int s = 0; s < SEGMENTS; s++) begin
      write_mask(mask_plan[s]);
      src_idle_pct   = (s % 4 == 1) ? 67 : (s % 4 == 3) ? 21 : 0;
      sink_stall_pct = (s % 4 == 2) ? 67 : (s % 4 == 3) ? 21 : 0;
      for (int i = 0; i < SEG_ITEMS; i++) send_cmd(random_cmd());
    end

    wait_drained();
    $display("Covered %0d texel loads, the texel preload among them, and %0d draws,",
             n_loads, n_draws);
    $display("under %0d mask settings and four pressure phases; %0d pixels compared.",
             n_masks, pixels_checked);
    if (mismatches == 0 && pixels_outstanding == 0) begin
      $display("** affine_texture_span_filler_top: PASSED **");
    end else begin
      $display("%0d mismatches, %0d pixels never arrived.", mismatches,
               pixels_outstanding);
      $display("** affine_texture_span_filler_top: FAILED **");
    end
    $finish;
  end

endmodule
